// ===== hw/rtl/ars_pkg.sv =====
// ----------------------------------------------------------------------------
// ars_pkg: shared types for the address region router and splitter
// Region table size, channel payloads, status codes, the cell link record
// and the region limit function.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam int MAX_REGIONS = 8;
  localparam int SLOT_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int OUT_SLOT_W  = 3;

  localparam logic [32:0] ADDR_TOP = 33'h1_0000_0000;

  typedef logic [SLOT_W-1:0] slot_t;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_ACCESS = 1'b1;

  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DUP      = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_UNMAPPED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] region_key;
    logic [31:0] region_start;
    logic [31:0] region_bytes;
    logic [31:0] access_addr;
    logic [31:0] access_len;
    logic        is_write;
  } in_item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [1:0]            status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [31:0]           target_key;
    logic [31:0]           local_offset;
    logic [31:0]           chunk_len;
    logic                  write_flag;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic [32:0] addr;
    logic [31:0] key;
  } probe_t;

  typedef struct packed {
    logic        en;
    slot_t       slot;
    logic [31:0] key;
    logic [31:0] base;
    logic [32:0] lim;
  } wr_t;

  typedef struct packed {
    logic        hit;
    slot_t       hit_slot;
    logic [31:0] hit_key;
    logic [31:0] hit_base;
    logic [32:0] hit_lim;
    logic        dup;
    slot_t       dup_slot;
    logic        free;
    slot_t       free_slot;
  } link_t;

  function automatic logic [32:0] region_limit(input logic [31:0] base,
                                               input logic [31:0] size);
    logic [32:0] sum;
    sum = {1'b0, base} + {1'b0, size};
    return (sum > ADDR_TOP) ? ADDR_TOP : sum;
  endfunction

endpackage

// ===== hw/rtl/ars_chan_if.sv =====
// ----------------------------------------------------------------------------
// ars_chan_if: request and result channels
// Valid/ready channels that carry one request or one result per transfer.
// ----------------------------------------------------------------------------
interface ars_in_if import ars_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ars_out_if import ars_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ars_cell.sv =====
// ----------------------------------------------------------------------------
// ars_cell: one region table entry
// Holds one region and updates the lookup record that passes down the row:
// first covering region, first matching id and first free entry.
// ----------------------------------------------------------------------------
module ars_cell import ars_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  slot_t  idx,
  input  probe_t probe,
  input  wr_t    wr,
  input  link_t  link_i,
  output link_t  link_o,
  output logic   valid_o
);

  logic        valid_r;
  logic [31:0] key_r;
  logic [31:0] base_r;
  logic [32:0] lim_r;
  logic        load;
  logic        covers;
  logic        key_match;

  assign load = wr.en && (wr.slot == idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r  <= wr.key;
      base_r <= wr.base;
      lim_r  <= wr.lim;
    end
  end

  assign covers    = valid_r && (probe.addr >= {1'b0, base_r}) && (probe.addr < lim_r);
  assign key_match = valid_r && (key_r == probe.key);
  assign valid_o   = valid_r;

  always_comb begin
    link_o = link_i;
    if (!link_i.hit && covers) begin
      link_o.hit      = 1'b1;
      link_o.hit_slot = idx;
      link_o.hit_key  = key_r;
      link_o.hit_base = base_r;
      link_o.hit_lim  = lim_r;
    end
    if (!link_i.dup && key_match) begin
      link_o.dup      = 1'b1;
      link_o.dup_slot = idx;
    end
    if (!link_i.free && !valid_r) begin
      link_o.free      = 1'b1;
      link_o.free_slot = idx;
    end
  end

endmodule

// ===== hw/rtl/ars_table.sv =====
// ----------------------------------------------------------------------------
// ars_table: row of region cells
// Chains the cells in slot order so that the lowest slot wins every search,
// and broadcasts the probe and the write port to all of them.
// ----------------------------------------------------------------------------
module ars_table import ars_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  probe_t                 probe,
  input  wr_t                    wr,
  output link_t                  result,
  output logic [MAX_REGIONS-1:0] valid_vec
);

  link_t links [MAX_REGIONS+1];

  assign links[0] = '0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    ars_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (slot_t'(i)),
      .probe   (probe),
      .wr      (wr),
      .link_i  (links[i]),
      .link_o  (links[i+1]),
      .valid_o (valid_vec[i])
    );
  end

  assign result = links[MAX_REGIONS];

endmodule

// ===== hw/rtl/address_region_router_splitter_top.sv =====
// ----------------------------------------------------------------------------
// address_region_router_splitter_top: region table with access splitting
// Adds regions to an ordered table and splits accesses into chunks, one per
// covering region, clipped at region ends; an uncovered address ends the
// access with an error result.
//
//   channel   dir  handshake           payload
//   in_chan   in   valid/ready         in_item_t (add or access request)
//   out_chan  out  valid/ready         out_item_t (chunk or acknowledgement)
//
// An add passes through a transfer, a table search and a result step.
// An access passes through a transfer step, and each of its results through a
// search of the cell row, then a split; a zero length access gives no result.
// A stalled result holds the block in its result step; a new request is
// taken once the final result of the previous one sits in the output register.
// Reset clears the entry valid bits directly; there is no clearing pass.
// ----------------------------------------------------------------------------
module address_region_router_splitter_top import ars_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ars_in_if.sink   in_chan,
  ars_out_if.source out_chan
);

  state_t      state_r, state_nxt;
  logic        kind_r;
  logic [31:0] key_r;
  logic [31:0] base_r;
  logic [32:0] lim_r;
  logic [32:0] addr_r;
  logic [31:0] remain_r;
  logic        wr_r;
  link_t       link_r;
  out_item_t   out_r;
  logic        out_valid_r;

  logic                   in_fire;
  logic                   out_free;
  logic                   emit_fire;
  logic                   done;
  logic [32:0]            avail;
  logic                   fits;
  logic [31:0]            take;
  out_item_t              res;
  probe_t                 probe;
  wr_t                    wr;
  link_t                  lookup;
  logic [MAX_REGIONS-1:0] valid_vec;

  ars_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .probe     (probe),
    .wr        (wr),
    .result    (lookup),
    .valid_vec (valid_vec)
  );

  assign probe.addr = addr_r;
  assign probe.key  = key_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign avail = link_r.hit_lim - addr_r;
  assign fits  = ({1'b0, remain_r} <= avail);
  assign take  = fits ? remain_r : avail[31:0];

  always_comb begin
    res              = '0;
    res.result_kind  = kind_r;
    done             = 1'b1;
    if (kind_r == REQ_ADD) begin
      res.result_kind = KIND_ACK;
      res.target_key  = key_r;
      res.last        = 1'b1;
      if (link_r.dup) begin
        res.status = STATUS_DUP;
        res.slot   = OUT_SLOT_W'(link_r.dup_slot);
      end else if (!link_r.free) begin
        res.status = STATUS_FULL;
      end else begin
        res.status = STATUS_OK;
        res.slot   = OUT_SLOT_W'(link_r.free_slot);
      end
    end else begin
      res.result_kind = KIND_CHUNK;
      res.write_flag  = wr_r;
      if (!link_r.hit) begin
        res.status       = STATUS_UNMAPPED;
        res.local_offset = addr_r[31:0];
        res.chunk_len    = remain_r;
        res.last         = 1'b1;
      end else begin
        res.status       = STATUS_OK;
        res.slot         = OUT_SLOT_W'(link_r.hit_slot);
        res.target_key   = link_r.hit_key;
        res.local_offset = addr_r[31:0] - link_r.hit_base;
        res.chunk_len    = take;
        res.last         = fits;
        done             = fits;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    emit_fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && ((in_chan.payload.req_type == REQ_ADD) ||
                        (in_chan.payload.access_len != '0))) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_fire = 1'b1;
          state_nxt = done ? ST_IDLE : ST_LOOK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign wr.en   = emit_fire && (kind_r == REQ_ADD) && !link_r.dup && link_r.free;
  assign wr.slot = link_r.free_slot;
  assign wr.key  = key_r;
  assign wr.base = base_r;
  assign wr.lim  = lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_chan.payload.req_type;
      key_r    <= in_chan.payload.region_key;
      base_r   <= in_chan.payload.region_start;
      lim_r    <= region_limit(in_chan.payload.region_start, in_chan.payload.region_bytes);
      addr_r   <= {1'b0, in_chan.payload.access_addr};
      remain_r <= in_chan.payload.access_len;
      wr_r     <= in_chan.payload.is_write;
    end else if (emit_fire && (kind_r == REQ_ACCESS)) begin
      addr_r   <= addr_r + {1'b0, take};
      remain_r <= remain_r - take;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      link_r <= lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_r <= res;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  // Entries fill from slot zero upward and are never dropped.
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + {{(MAX_REGIONS-1){1'b0}}, 1'b1})) == '0)
    else $error("region table valid bits are not packed from slot zero");

  a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) >= $past($countones(valid_vec)))
    else $error("region table lost an entry");

  a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.result_kind == KIND_CHUNK) && (out_r.status == STATUS_OK))
    |-> (out_r.chunk_len != '0))
    else $error("empty access chunk");

  a_top_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && (kind_r == REQ_ACCESS) && addr_r[32]) |-> !link_r.hit)
    else $error("address past the end of the address space matched a region");

endmodule
